>>> rtl/assert_macros.svh
// Assertion macros for the RTL files.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Condition that must never hold
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("assertion failed");

`endif

>>> rtl/iisat_pkg.sv
// Shared types and constants of the three-channel integral image block.
// No dependencies; used by all iisat modules and the top level.
package iisat_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int NUM_LANES  = 3;

    localparam int CH_W    = 8;
    localparam int SUM_W   = 32;
    localparam int SIZE_W  = 12;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(MAX_HEIGHT);

    typedef struct packed {
        logic [CH_W-1:0] channel_0;
        logic [CH_W-1:0] channel_1;
        logic [CH_W-1:0] channel_2;
    } t_pixel;

    typedef struct packed {
        logic [SUM_W-1:0] sum_0;
        logic [SUM_W-1:0] sum_1;
        logic [SUM_W-1:0] sum_2;
        logic             frame_end;
    } t_result;

    // Control from the sequencer to the lanes and the output stage
    typedef struct packed {
        logic             accept;     // pixel taken this cycle
        logic             advance;    // stage-1 item moves to the output register
        logic             s1_valid;   // stage 1 holds an item
        logic [COL_W-1:0] rd_addr;    // line-buffer column of the pixel being taken
        logic [COL_W-1:0] wr_addr;    // line-buffer column of the stage-1 item
        logic             use_prev;   // stage-1 item is below the first row
        logic             clr_row;    // pixel being taken ends its row
        logic             fwd_hit;    // read collides with the write of this cycle
        logic             frame_end;  // stage-1 item is the last of the frame
    } t_lane_ctl;

endpackage

>>> rtl/integral_image_three_channel_top.sv
// Top level of the three-channel integral image block.
// Depends on iisat_pkg, iisat_ctrl, iisat_lane, iisat_merge and assert_macros.svh.

// Three-channel summed-area table over a raster pixel stream. Each accepted pixel yields
// one item with the three integral sums (modulo 2^32) and a mark on the last pixel of the
// frame. Throughput is one pixel per clock while the output does not stall; an item
// passes one line-buffer read stage and one output register on its way out. The rate
// rests on the read-modify-write of each lane's 2048 x 32 line buffer, whose read is
// bypassed from the write of the same cycle when both address the same column. The line
// buffers are not cleared: the first row of every frame ignores them. The user must write
// the frame size through the configuration port (index 0 width, index 1 height, 12 bits
// each, zero counts as one, values above 2048 saturate) only while the block is idle;
// the block itself does not enforce it.
`include "assert_macros.svh"

module integral_image_three_channel_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [iisat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [iisat_pkg::SIZE_W-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  iisat_pkg::t_pixel               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output iisat_pkg::t_result              o_out_data
);

    iisat_pkg::t_lane_ctl        w_ctl;
    logic                        w_out_free;
    logic [iisat_pkg::SUM_W-1:0] w_sum_0;
    logic [iisat_pkg::SUM_W-1:0] w_sum_1;
    logic [iisat_pkg::SUM_W-1:0] w_sum_2;

    iisat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_free  (w_out_free),
        .o_ctl       (w_ctl)
    );

    // One lane per color channel
    iisat_lane u_lane_0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_pixel (i_in_data.channel_0),
        .o_sum   (w_sum_0)
    );

    iisat_lane u_lane_1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_pixel (i_in_data.channel_1),
        .o_sum   (w_sum_1)
    );

    iisat_lane u_lane_2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_pixel (i_in_data.channel_2),
        .o_sum   (w_sum_2)
    );

    iisat_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_sum_0     (w_sum_0),
        .i_sum_1     (w_sum_1),
        .i_sum_2     (w_sum_2),
        .o_out_free  (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // A taken pixel always occupies stage 1 in the next cycle
    `ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, w_ctl.accept, w_ctl.s1_valid)
    // An item leaving stage 1 always shows up at the output
    `ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, w_ctl.advance, o_out_valid)
    // No pixel is taken while stage 1 is held by a stalled output
    `ASSERT_NEVER(a_no_overrun, i_clk, i_rst_n,
        w_ctl.accept && w_ctl.s1_valid && !w_ctl.advance)
    // Bypass only when stage 1 really writes back
    `ASSERT_IMPLIES(a_fwd_needs_write, i_clk, i_rst_n, w_ctl.fwd_hit,
        w_ctl.advance && w_ctl.s1_valid)

endmodule

>>> rtl/iisat_ctrl.sv
// Sequencer: frame size registers, column/row counters, stage-1 valid and handshake.
// Depends on iisat_pkg.
module iisat_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [iisat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [iisat_pkg::SIZE_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_out_free,
    output iisat_pkg::t_lane_ctl           o_ctl
);

    logic [iisat_pkg::SIZE_W-1:0] r_width;
    logic [iisat_pkg::SIZE_W-1:0] r_height;
    logic [iisat_pkg::COL_W-1:0]  r_col;
    logic [iisat_pkg::ROW_W-1:0]  r_row;
    logic                         r_s1_valid;
    logic [iisat_pkg::COL_W-1:0]  r_s1_addr;
    logic                         r_s1_use_prev;
    logic                         r_s1_last;

    logic [iisat_pkg::SIZE_W-1:0] w_width;
    logic [iisat_pkg::SIZE_W-1:0] w_height;
    logic                         w_last_col;
    logic                         w_last_row;
    logic                         w_advance;
    logic                         w_accept;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= iisat_pkg::WIDTH_RESET;
            r_height <= iisat_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                iisat_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                iisat_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective frame size: zero counts as one, large values saturate
    always_comb begin
        if (r_width == '0)
            w_width = iisat_pkg::SIZE_W'(1);
        else if (r_width > iisat_pkg::WIDTH_MAX)
            w_width = iisat_pkg::WIDTH_MAX;
        else
            w_width = r_width;
        if (r_height == '0)
            w_height = iisat_pkg::SIZE_W'(1);
        else if (r_height > iisat_pkg::HEIGHT_MAX)
            w_height = iisat_pkg::HEIGHT_MAX;
        else
            w_height = r_height;
    end

    assign w_last_col = ({1'b0, r_col} + iisat_pkg::SIZE_W'(1)) >= w_width;
    assign w_last_row = ({1'b0, r_row} + iisat_pkg::SIZE_W'(1)) >= w_height;

    // Handshake: stage 1 empties into the output register when that has room
    assign w_advance  = r_s1_valid && i_out_free;
    assign o_in_stall = r_s1_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_last_col) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + iisat_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + iisat_pkg::COL_W'(1);
            end
        end
    end

    // Stage-1 occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage-1 item attributes
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_addr     <= r_col;
            r_s1_use_prev <= (r_row != '0);
            r_s1_last     <= w_last_col && w_last_row;
        end
    end

    always_comb begin
        o_ctl.accept    = w_accept;
        o_ctl.advance   = w_advance;
        o_ctl.s1_valid  = r_s1_valid;
        o_ctl.rd_addr   = r_col;
        o_ctl.wr_addr   = r_s1_addr;
        o_ctl.use_prev  = r_s1_use_prev;
        o_ctl.clr_row   = w_last_col;
        o_ctl.fwd_hit   = w_advance && (r_col == r_s1_addr);
        o_ctl.frame_end = r_s1_last;
    end

endmodule

>>> rtl/iisat_lane.sv
// One channel lane: running row sum, previous-row line buffer and the integral add.
// Depends on iisat_pkg.
module iisat_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  iisat_pkg::t_lane_ctl        i_ctl,
    input  logic [iisat_pkg::CH_W-1:0]  i_pixel,
    output logic [iisat_pkg::SUM_W-1:0] o_sum
);

    logic [iisat_pkg::SUM_W-1:0] r_line [iisat_pkg::MAX_WIDTH];
    logic [iisat_pkg::SUM_W-1:0] r_row_sum;
    logic [iisat_pkg::SUM_W-1:0] r_s1_row;
    logic [iisat_pkg::SUM_W-1:0] r_rdata;
    logic [iisat_pkg::SUM_W-1:0] r_fwd_data;
    logic                        r_fwd;

    logic [iisat_pkg::SUM_W-1:0] w_row_new;
    logic [iisat_pkg::SUM_W-1:0] w_prev;

    assign w_row_new = r_row_sum + iisat_pkg::SUM_W'(i_pixel);

    // Running sum along the current row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum <= '0;
        end else if (i_ctl.accept) begin
            r_row_sum <= i_ctl.clr_row ? '0 : w_row_new;
        end
    end

    // Stage 1: row sum, line-buffer read, bypass of a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_s1_row   <= w_row_new;
            r_rdata    <= r_line[i_ctl.rd_addr];
            r_fwd      <= i_ctl.fwd_hit;
            r_fwd_data <= o_sum;
        end
    end

    // Line buffer write-back as the item leaves stage 1
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_line[i_ctl.wr_addr] <= o_sum;
        end
    end

    assign w_prev = r_fwd ? r_fwd_data : r_rdata;
    assign o_sum  = i_ctl.use_prev ? (r_s1_row + w_prev) : r_s1_row;

endmodule

>>> rtl/iisat_merge.sv
// Output register that joins the three lane sums and the frame-end mark into one item.
// Depends on iisat_pkg.
module iisat_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  iisat_pkg::t_lane_ctl        i_ctl,
    input  logic [iisat_pkg::SUM_W-1:0] i_sum_0,
    input  logic [iisat_pkg::SUM_W-1:0] i_sum_1,
    input  logic [iisat_pkg::SUM_W-1:0] i_sum_2,
    output logic                        o_out_free,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output iisat_pkg::t_result          o_out_data
);

    logic               r_out_valid;
    iisat_pkg::t_result r_out_data;

    // Room for a new item when empty or when the held one is taken now
    assign o_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_out_data.sum_0     <= i_sum_0;
            r_out_data.sum_1     <= i_sum_1;
            r_out_data.sum_2     <= i_sum_2;
            r_out_data.frame_end <= i_ctl.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> test/tb.sv
// Self-checking bench for integral_image_three_channel_top: random and directed pixel streams.
// Depends on iisat_pkg and the RTL of the block; carries its own summed-area-table predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 4000;  // cycles with no item moving on either side
    localparam int RANDOM_ITEMS = 950;
    localparam int HOLDOFF_LEN  = 300;

    // DUT connections; the inputs are driven to known values from time zero
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [iisat_pkg::CFG_IDX_W-1:0] i_cfg_index = iisat_pkg::REG_IMAGE_WIDTH;
    logic [iisat_pkg::SIZE_W-1:0]    i_cfg_data  = '0;
    logic                            i_in_valid  = 1'b0;
    iisat_pkg::t_pixel               i_in_data   = '0;
    logic                            i_out_stall = 1'b0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    iisat_pkg::t_result              o_out_data;

    integral_image_three_channel_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: frame size shadow, line buffer, row sums, position
    logic [iisat_pkg::SIZE_W-1:0] cfg_width  = iisat_pkg::WIDTH_RESET;
    logic [iisat_pkg::SIZE_W-1:0] cfg_height = iisat_pkg::HEIGHT_RESET;
    logic [iisat_pkg::SUM_W-1:0]  line_sums [iisat_pkg::NUM_LANES][iisat_pkg::MAX_WIDTH];
    logic [iisat_pkg::SUM_W-1:0]  row_sums  [iisat_pkg::NUM_LANES] = '{default: '0};
    int unsigned                  col_pos = 0;
    int unsigned                  row_pos = 0;

    // Stimulus and scoreboard bookkeeping
    iisat_pkg::t_pixel  pixel_q [$];
    iisat_pkg::t_result sum_q   [$];
    iisat_pkg::t_result want;
    int          items_in_flight = 0;
    int          failures        = 0;
    int          results_seen    = 0;
    int          frames_closed   = 0;
    int          settings_used   = 0;
    int          random_items    = 0;
    int          gap_left        = 0;
    int          stall_left      = 0;
    int          outhold_req     = 0;
    int          idle_cycles     = 0;
    bit          calm            = 1'b0;

    // Frame size as the block sees a register value
    function automatic int unsigned eff_size(input logic [iisat_pkg::SIZE_W-1:0] v,
                                             input int unsigned cap);
        if (v == 0)
            return 1;
        if (v > cap)
            return cap;
        return 32'(v);
    endfunction

    // One pixel through the summed-area table; advances the position
    function automatic iisat_pkg::t_result integrate_pixel(input iisat_pkg::t_pixel px);
        logic [iisat_pkg::CH_W-1:0]  chan [iisat_pkg::NUM_LANES];
        logic [iisat_pkg::SUM_W-1:0] sums [iisat_pkg::NUM_LANES];
        logic [iisat_pkg::SUM_W-1:0] total;
        iisat_pkg::t_result          res;
        int unsigned                 w, h, col;
        bit                          last_col, last_row;
        chan[0] = px.channel_0;
        chan[1] = px.channel_1;
        chan[2] = px.channel_2;
        w   = eff_size(cfg_width, iisat_pkg::MAX_WIDTH);
        h   = eff_size(cfg_height, iisat_pkg::MAX_HEIGHT);
        col = (col_pos >= iisat_pkg::MAX_WIDTH) ? iisat_pkg::MAX_WIDTH - 1 : col_pos;
        for (int c = 0; c < iisat_pkg::NUM_LANES; c++) begin
            row_sums[c] += iisat_pkg::SUM_W'(chan[c]);
            total = row_sums[c];
            // first row of a frame ignores the line buffer
            if (row_pos > 0)
                total += line_sums[c][col];
            line_sums[c][col] = total;
            sums[c] = total;
        end
        last_col      = (col_pos + 1 >= w);
        last_row      = (row_pos + 1 >= h);
        res.sum_0     = sums[0];
        res.sum_1     = sums[1];
        res.sum_2     = sums[2];
        res.frame_end = last_col && last_row;
        if (last_col) begin
            col_pos = 0;
            for (int c = 0; c < iisat_pkg::NUM_LANES; c++)
                row_sums[c] = '0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 93)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic iisat_pkg::t_pixel rand_pixel(input bit extremes);
        iisat_pkg::t_pixel px;
        if (extremes) begin
            px.channel_0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.channel_1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.channel_2 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
            px = iisat_pkg::t_pixel'(24'($urandom_range(0, 24'hFF_FFFF)));
        end
        return px;
    endfunction

    task automatic push_pixel(input iisat_pkg::t_pixel px);
        pixel_q.push_back(px);
        items_in_flight++;
    endtask

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++)
            push_pixel(rand_pixel($urandom_range(0, 9) < 3));
    endtask

    // Sender pause until every pushed pixel has come back as a result
    task automatic wait_idle();
        do @(posedge i_clk); while (items_in_flight != 0);
    endtask

    // Frame size update, only once the block has drained
    task automatic configure(input bit wr_w, input logic [iisat_pkg::SIZE_W-1:0] w,
                             input bit wr_h, input logic [iisat_pkg::SIZE_W-1:0] h);
        wait_idle();
        repeat (2) @(posedge i_clk);
        if (wr_w) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= iisat_pkg::REG_IMAGE_WIDTH;
            i_cfg_data  <= w;
            cfg_width    = w;
        end
        if (wr_h) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= iisat_pkg::REG_IMAGE_HEIGHT;
            i_cfg_data  <= h;
            cfg_height   = h;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Driver: presents queued pixels, holds them while stalled, predicts on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left    = 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                sum_q.push_back(integrate_pixel(i_in_data));
            if (i_in_valid && o_in_stall) begin
                // stalled item stays as it is
            end else if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (pixel_q.size() > 0) begin
                i_in_data  <= pixel_q.pop_front();
                i_in_valid <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25)
                    gap_left = pick_idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction, drives stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left   = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (o_out_data.frame_end === 1'b1)
                    frames_closed++;
                if (items_in_flight > 0)
                    items_in_flight--;
                if (sum_q.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("tb: unexpected result %p", o_out_data);
                end else begin
                    want = sum_q.pop_front();
                    if (o_out_data.sum_0 !== want.sum_0 || o_out_data.sum_1 !== want.sum_1 ||
                        o_out_data.sum_2 !== want.sum_2 ||
                        o_out_data.frame_end !== want.frame_end) begin
                        failures++;
                        if (failures <= 10)
                            $display("tb: result %0d expected %h %h %h end %b, got %h %h %h end %b",
                                     results_seen, want.sum_0, want.sum_1, want.sum_2,
                                     want.frame_end, o_out_data.sum_0, o_out_data.sum_1,
                                     o_out_data.sum_2, o_out_data.frame_end);
                    end
                end
            end
            // a requested hold-off is timed here, cycle by cycle
            if (outhold_req > 0) begin
                stall_left  = outhold_req;
                outhold_req = 0;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < 20) begin
                i_out_stall <= 1'b1;
                stall_left   = pick_idle_len() - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: no progress for %0d cycles", IDLE_LIMIT);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial begin : stimulus
        int unsigned w_eff, h_eff, frame, n;
        logic [iisat_pkg::SIZE_W-1:0] new_w, new_h;
        bit wr_w, wr_h;
        int r;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size (640 x 480): three pixels, two of them at the extremes
        push_pixel({8'h00, 8'h00, 8'h00});
        push_pixel({8'hFF, 8'hFF, 8'hFF});
        push_pixel({8'h80, 8'h01, 8'hFE});
        // shrink width under the column counter, height zero means one row
        configure(1'b1, 12'd3, 1'b1, 12'd0);
        push_pixel({8'hFF, 8'h00, 8'hFF});
        // one-pixel frames
        configure(1'b1, 12'd1, 1'b1, 12'd1);
        push_pixel({8'hFF, 8'hFF, 8'hFF});
        push_pixel({8'h00, 8'h7F, 8'hFF});
        // zero width counts as one column
        configure(1'b1, 12'd0, 1'b1, 12'd3);
        repeat (3) push_pixel({8'hFF, 8'hFF, 8'hFF});
        configure(1'b1, 12'd2, 1'b1, 12'd2);
        push_pixel({8'hFF, 8'h00, 8'h55});
        push_pixel({8'h00, 8'hFF, 8'hAA});
        push_pixel({8'hFF, 8'hFF, 8'h01});
        push_pixel({8'h01, 8'h00, 8'hFF});
        // height cut below the row counter in mid-frame
        configure(1'b0, 12'd0, 1'b1, 12'd5);
        repeat (6) push_pixel({8'hFF, 8'hFF, 8'hFF});
        configure(1'b0, 12'd0, 1'b1, 12'd2);
        push_pixel({8'h10, 8'h20, 8'h30});
        push_pixel({8'hFF, 8'hFF, 8'hFF});

        // saturated sizes: part of a long row and of a tall column, then cut short
        configure(1'b1, 12'hFFF, 1'b1, 12'd1);
        send_random(64);
        configure(1'b1, 12'd3, 1'b0, 12'd0);
        send_random(4);
        configure(1'b1, 12'd1, 1'b1, 12'hFFF);
        send_random(64);
        configure(1'b0, 12'd0, 1'b1, 12'd2);
        send_random(3);

        // output held off for a long stretch while the sender keeps offering
        configure(1'b1, 12'd8, 1'b1, 12'd5);
        calm        = 1'b1;
        outhold_req = HOLDOFF_LEN;
        send_random(120);
        random_items += 120;

        // random phases: new size at frame starts, safe changes in mid-frame
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            calm  = ($urandom_range(0, 4) == 0);
            w_eff = eff_size(cfg_width, iisat_pkg::MAX_WIDTH);
            r     = $urandom_range(0, 9);
            new_h = ($urandom_range(0, 99) < 5) ? 12'd0 :
                    ($urandom_range(0, 99) < 80) ? 12'($urandom_range(1, 6)) :
                    12'($urandom_range(7, 30));
            if (col_pos == 0 && row_pos == 0) begin
                r = $urandom_range(0, 99);
                new_w = (r < 5)  ? 12'd0 :
                        (r < 75) ? 12'($urandom_range(1, 12)) :
                        (r < 95) ? 12'($urandom_range(13, 64)) :
                        (r < 98) ? 12'($urandom_range(65, 300)) :
                        12'($urandom_range(2049, 4095));
                r    = $urandom_range(0, 9);
                wr_w = (r != 0);
                wr_h = (r != 1);
            end else begin
                // width may only shrink inside a frame
                new_w = 12'($urandom_range(0, w_eff));
                wr_w  = (r < 4);
                wr_h  = !wr_w || (r < 2);
            end
            configure(wr_w, new_w, wr_h, new_h);
            w_eff = eff_size(cfg_width, iisat_pkg::MAX_WIDTH);
            h_eff = eff_size(cfg_height, iisat_pkg::MAX_HEIGHT);
            frame = w_eff * h_eff;
            n     = $urandom_range(1, (2 * frame < 200) ? 2 * frame : 200);
            send_random(n);
            random_items += n;
        end

        // drain, then let the pipeline settle before the final check
        wait_idle();
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        if (sum_q.size() != 0) begin
            failures++;
            $display("tb: %0d predicted results never arrived", sum_q.size());
        end
        $display("tb: %0d pixels checked across %0d size settings, %0d frames ended",
                 results_seen, settings_used, frames_closed);
        $display("tb: covered zero and saturated sizes, mid-frame resizing, a %0d-cycle hold-off",
                 HOLDOFF_LEN);
        if (failures == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/iisat_pkg.sv
rtl/iisat_ctrl.sv
rtl/iisat_lane.sv
rtl/iisat_merge.sv
rtl/integral_image_three_channel_top.sv
test/tb.sv
